@@ src/hrbp_pkg.sv @@
// shared types, constants and byte helpers for the http request byte parser
package hrbp_pkg;

  typedef enum logic [5:0] {
    PH_METHOD_START, PH_METHOD, PH_URI_START, PH_URI,
    PH_V_H, PH_V_HT, PH_V_HTT, PH_V_HTTP, PH_V_SLASH,
    PH_MAJ_START, PH_MAJ, PH_MIN_START, PH_MIN, PH_VER_LF,
    PH_HDR_START, PH_HDR_LWS, PH_HDR_NAME, PH_HDR_SPACE, PH_HDR_VALUE,
    PH_HDR_LF, PH_END_LF, PH_BODY,
    PH_CK_SIZE, PH_CK_EXT_NAME, PH_CK_EXT_VALUE, PH_CK_SIZE_LF,
    PH_CK_LAST, PH_CK_FINAL_LF, PH_CK_TRAILER_NAME, PH_CK_TRAILER_VALUE,
    PH_CK_DATA, PH_CK_DATA_CR, PH_CK_DATA_LF
  } phase_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_DONE       = 2'd1,
    ST_ERROR      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CL_FRAMING = 3'd0,
    CL_METHOD  = 3'd1,
    CL_URI     = 3'd2,
    CL_HNAME   = 3'd3,
    CL_HVALUE  = 3'd4,
    CL_BODY    = 3'd5
  } class_t;

  // incremental word matcher: position and one still-matching bit per word
  typedef struct packed {
    logic [4:0] pos;
    logic [2:0] ok;
  } match_t;

  localparam match_t MATCH_CLEAR = '{pos: 5'd0, ok: 3'b111};
  localparam logic [4:0] POS_MAX = 5'd31;

  localparam int WORD_BYTES = 17;
  typedef logic [8*WORD_BYTES-1:0] word_t;

  localparam word_t W_POST   = "POST";
  localparam word_t W_PUT    = "PUT";
  localparam word_t W_CLEN   = "Content-Length";
  localparam word_t W_TENC   = "Transfer-Encoding";
  localparam word_t W_CONN   = "Connection";
  localparam word_t W_CHUNK  = "chunked";
  localparam word_t W_KALIVE = "Keep-Alive";

  localparam logic [4:0] L_POST   = 5'd4;
  localparam logic [4:0] L_PUT    = 5'd3;
  localparam logic [4:0] L_CLEN   = 5'd14;
  localparam logic [4:0] L_TENC   = 5'd17;
  localparam logic [4:0] L_CONN   = 5'd10;
  localparam logic [4:0] L_CHUNK  = 5'd7;
  localparam logic [4:0] L_KALIVE = 5'd10;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CTLHI = 8'd31;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic is_ctl(input logic [7:0] b);
    is_ctl = (b <= CH_CTLHI) || (b == CH_DEL);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    is_alnum = is_alpha(b) || is_digit(b);
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    logic r;
    r = !(b > CH_DEL) && !is_ctl(b);
    if (b inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
                  "[", "]", "?", "=", "{", "}", " "}) begin
      r = 1'b0;
    end
    is_token = r;
  endfunction

  // byte of a word at a position, the word sits in the low bytes
  function automatic logic same_char(input word_t w, input logic [4:0] len,
                                     input logic [4:0] p, input logic [7:0] b,
                                     input logic fold);
    logic [7:0] c;
    c = 8'd0;
    if (p < len) begin
      c = w[8*(len - 5'd1 - p) +: 8];
    end
    same_char = (p < len) && (fold ? (to_lower(b) == to_lower(c)) : (b == c));
  endfunction

  function automatic match_t match_step(input match_t m, input logic [2:0] same);
    match_t r;
    r.ok  = m.ok & same;
    r.pos = (m.pos < POS_MAX) ? m.pos + 5'd1 : m.pos;
    match_step = r;
  endfunction

  function automatic logic [7:0] sat_dec(input logic [7:0] v, input logic [7:0] b);
    logic [11:0] r;
    r = {4'd0, v} * 12'd10 + {4'd0, b - "0"};
    sat_dec = (r > 12'd255) ? 8'd255 : r[7:0];
  endfunction

endpackage

@@ src/http_request_byte_parser.sv @@
// http request byte parser: one byte in, one tagged result out per byte
//
//  channel | ports        | carries
//  --------+--------------+------------------------------------------------
//  in      | in_t*        | tdata[7:0] in_byte
//  out     | out_t*       | tdata: status, data_byte, version_major,
//          |              |   version_minor, keep_alive, chunked;
//          |              |   tuser: class, header_start
//
// one byte per cycle sustained while the output is not stalled; two register
// stages (input register, then the parse step into the result register), so a
// byte's result is offered once it has passed both registers in that order
// the parse state loop is combinational between its registers, so every byte
// is fully handled in the cycle it leaves the input register
// rst_n is synchronous; it clears the parse state and both valid flags
// a stalled output holds its result and backs up into the input register
module http_request_byte_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [1:0] status, [9:2] data_byte,
                                  // [17:10] version_major, [25:18] version_minor,
                                  // [26] keep_alive, [27] chunked, [31:28] zero
  output logic [3:0]  out_tuser   // [2:0] byte_class, [3] header_start
);

  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // result register
  logic        out_valid_r;
  logic [27:0] out_data_r;
  logic [3:0]  out_user_r;

  // parse state
  hrbp_pkg::phase_t phase_r, phase_nxt;
  hrbp_pkg::match_t meth_r, meth_nxt, name_r, name_nxt, val_r, val_nxt;
  logic [7:0]    major_r, major_nxt, minor_r, minor_nxt;
  logic          any_hdr_r, any_hdr_nxt;
  logic [LB-1:0] num_r, num_nxt;
  logic [1:0]    num_ph_r, num_ph_nxt;
  logic          num_neg_r, num_neg_nxt;
  logic [1:0]    conn_r, conn_nxt;       // bit0 seen, bit1 keep-alive
  logic [LB-1:0] body_r, body_nxt;
  logic          chunked_r, chunked_nxt;
  logic [LB-1:0] hex_r, hex_nxt;
  logic          hex_open_r, hex_open_nxt;
  logic          ka_r, ka_nxt;

  logic advance, fire;
  hrbp_pkg::status_t status;
  hrbp_pkg::class_t  cls;
  logic              hs;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // helper values for the current byte
  logic [7:0]    b;
  logic [7:0]    bl;
  logic          method_ok, name_cl, name_te, name_conn, val_chunk, val_ka;
  logic [2:0]    meth_same, name_same, val_same;
  logic [LB+3:0] dec_sum, hex_sum;
  logic [3:0]    hex_digit;
  logic [LB-1:0] body_dec;

  assign b  = in_byte_r;
  assign bl = hrbp_pkg::to_lower(b);

  assign method_ok = (meth_r.ok[0] && meth_r.pos == hrbp_pkg::L_POST) ||
                     (meth_r.ok[1] && meth_r.pos == hrbp_pkg::L_PUT);
  assign name_cl   = name_r.ok[0] && name_r.pos == hrbp_pkg::L_CLEN;
  assign name_te   = name_r.ok[1] && name_r.pos == hrbp_pkg::L_TENC;
  assign name_conn = name_r.ok[2] && name_r.pos == hrbp_pkg::L_CONN;
  assign val_chunk = val_r.ok[0] && val_r.pos == hrbp_pkg::L_CHUNK;
  assign val_ka    = val_r.ok[1] && val_r.pos == hrbp_pkg::L_KALIVE;

  assign meth_same = {1'b0,
    hrbp_pkg::same_char(hrbp_pkg::W_PUT, hrbp_pkg::L_PUT, meth_r.pos, b, 1'b0),
    hrbp_pkg::same_char(hrbp_pkg::W_POST, hrbp_pkg::L_POST, meth_r.pos, b, 1'b0)};
  assign val_same = {1'b0,
    hrbp_pkg::same_char(hrbp_pkg::W_KALIVE, hrbp_pkg::L_KALIVE, val_r.pos, b, 1'b1),
    hrbp_pkg::same_char(hrbp_pkg::W_CHUNK, hrbp_pkg::L_CHUNK, val_r.pos, b, 1'b1)};
  // a new header name starts matching from position zero
  assign name_same = {
    hrbp_pkg::same_char(hrbp_pkg::W_CONN, hrbp_pkg::L_CONN,
                        (phase_r == hrbp_pkg::PH_HDR_START) ? 5'd0 : name_r.pos, b, 1'b1),
    hrbp_pkg::same_char(hrbp_pkg::W_TENC, hrbp_pkg::L_TENC,
                        (phase_r == hrbp_pkg::PH_HDR_START) ? 5'd0 : name_r.pos, b, 1'b1),
    hrbp_pkg::same_char(hrbp_pkg::W_CLEN, hrbp_pkg::L_CLEN,
                        (phase_r == hrbp_pkg::PH_HDR_START) ? 5'd0 : name_r.pos, b, 1'b1)};

  // saturating decimal and hex accumulators, times ten as two shifts
  assign dec_sum = ({4'd0, num_r} << 3) + ({4'd0, num_r} << 1) +
                   {{LB{1'b0}}, b[3:0] - 4'd0};
  assign hex_digit = hrbp_pkg::is_digit(b) ? b[3:0] : (bl[3:0] + 4'd9);
  assign hex_sum   = ({4'd0, hex_r} << 4) | {{LB{1'b0}}, hex_digit};
  assign body_dec  = (body_r != '0) ? body_r - {{(LB-1){1'b0}}, 1'b1} : body_r;

  always_comb begin
    logic err;
    err          = 1'b0;
    status       = hrbp_pkg::ST_INCOMPLETE;
    cls          = hrbp_pkg::CL_FRAMING;
    hs           = 1'b0;
    phase_nxt    = phase_r;
    meth_nxt     = meth_r;
    name_nxt     = name_r;
    val_nxt      = val_r;
    major_nxt    = major_r;
    minor_nxt    = minor_r;
    any_hdr_nxt  = any_hdr_r;
    num_nxt      = num_r;
    num_ph_nxt   = num_ph_r;
    num_neg_nxt  = num_neg_r;
    conn_nxt     = conn_r;
    body_nxt     = body_r;
    chunked_nxt  = chunked_r;
    hex_nxt      = hex_r;
    hex_open_nxt = hex_open_r;
    ka_nxt       = ka_r;

    // per-phase byte handling; in a header value the matcher and number parser run together
    case (phase_r)
      hrbp_pkg::PH_METHOD_START, hrbp_pkg::PH_METHOD: begin
        if (phase_r == hrbp_pkg::PH_METHOD && b == hrbp_pkg::CH_SP) begin
          phase_nxt = hrbp_pkg::PH_URI_START;
        end else if (!hrbp_pkg::is_token(b)) begin
          err = 1'b1;
        end else begin
          phase_nxt = hrbp_pkg::PH_METHOD;
          cls       = hrbp_pkg::CL_METHOD;
          meth_nxt  = hrbp_pkg::match_step(meth_r, meth_same);
        end
      end
      hrbp_pkg::PH_URI_START: begin
        if (hrbp_pkg::is_ctl(b)) begin
          err = 1'b1;
        end else begin
          phase_nxt = hrbp_pkg::PH_URI;
          cls       = hrbp_pkg::CL_URI;
        end
      end
      hrbp_pkg::PH_URI: begin
        if (b == hrbp_pkg::CH_SP) begin
          phase_nxt = hrbp_pkg::PH_V_H;
        end else if (b == hrbp_pkg::CH_CR) begin
          // early end of line: http/0.9
          major_nxt = 8'd0;
          minor_nxt = 8'd9;
          status    = hrbp_pkg::ST_DONE;
        end else if (hrbp_pkg::is_ctl(b)) begin
          err = 1'b1;
        end else begin
          cls = hrbp_pkg::CL_URI;
        end
      end
      hrbp_pkg::PH_V_H: begin
        if (b == "H") phase_nxt = hrbp_pkg::PH_V_HT;
        else err = 1'b1;
      end
      hrbp_pkg::PH_V_HT: begin
        if (b == "T") phase_nxt = hrbp_pkg::PH_V_HTT;
        else err = 1'b1;
      end
      hrbp_pkg::PH_V_HTT: begin
        if (b == "T") phase_nxt = hrbp_pkg::PH_V_HTTP;
        else err = 1'b1;
      end
      hrbp_pkg::PH_V_HTTP: begin
        if (b == "P") phase_nxt = hrbp_pkg::PH_V_SLASH;
        else err = 1'b1;
      end
      hrbp_pkg::PH_V_SLASH: begin
        if (b == "/") begin
          major_nxt = 8'd0;
          minor_nxt = 8'd0;
          phase_nxt = hrbp_pkg::PH_MAJ_START;
        end else begin
          err = 1'b1;
        end
      end
      hrbp_pkg::PH_MAJ_START: begin
        if (hrbp_pkg::is_digit(b)) begin
          major_nxt = {4'd0, b[3:0]};
          phase_nxt = hrbp_pkg::PH_MAJ;
        end else begin
          err = 1'b1;
        end
      end
      hrbp_pkg::PH_MAJ: begin
        if (b == ".") phase_nxt = hrbp_pkg::PH_MIN_START;
        else if (hrbp_pkg::is_digit(b)) major_nxt = hrbp_pkg::sat_dec(major_r, b);
        else err = 1'b1;
      end
      hrbp_pkg::PH_MIN_START: begin
        if (hrbp_pkg::is_digit(b)) begin
          minor_nxt = {4'd0, b[3:0]};
          phase_nxt = hrbp_pkg::PH_MIN;
        end else begin
          err = 1'b1;
        end
      end
      hrbp_pkg::PH_MIN: begin
        if (b == hrbp_pkg::CH_CR) phase_nxt = hrbp_pkg::PH_VER_LF;
        else if (hrbp_pkg::is_digit(b)) minor_nxt = hrbp_pkg::sat_dec(minor_r, b);
        else err = 1'b1;
      end
      hrbp_pkg::PH_VER_LF, hrbp_pkg::PH_HDR_LF: begin
        if (b == hrbp_pkg::CH_LF) phase_nxt = hrbp_pkg::PH_HDR_START;
        else err = 1'b1;
      end
      hrbp_pkg::PH_HDR_START: begin
        if (b == hrbp_pkg::CH_CR) begin
          if (any_hdr_r && !conn_r[0] && name_conn) conn_nxt = {val_ka, 1'b1};
          phase_nxt = hrbp_pkg::PH_END_LF;
        end else if (any_hdr_r && (b == hrbp_pkg::CH_SP || b == hrbp_pkg::CH_TAB)) begin
          phase_nxt = hrbp_pkg::PH_HDR_LWS;
        end else if (!hrbp_pkg::is_token(b)) begin
          err = 1'b1;
        end else begin
          if (any_hdr_r && !conn_r[0] && name_conn) conn_nxt = {val_ka, 1'b1};
          any_hdr_nxt = 1'b1;
          name_nxt    = hrbp_pkg::match_step(hrbp_pkg::MATCH_CLEAR, name_same);
          val_nxt     = hrbp_pkg::MATCH_CLEAR;
          num_nxt     = '0;
          num_ph_nxt  = 2'd0;
          num_neg_nxt = 1'b0;
          cls         = hrbp_pkg::CL_HNAME;
          hs          = 1'b1;
          phase_nxt   = hrbp_pkg::PH_HDR_NAME;
        end
      end
      hrbp_pkg::PH_HDR_LWS, hrbp_pkg::PH_HDR_VALUE: begin
        if (b == hrbp_pkg::CH_CR) begin
          if (phase_r == hrbp_pkg::PH_HDR_VALUE && method_ok) begin
            if (name_cl) body_nxt = num_neg_r ? '0 : num_r;
            else if (name_te && val_chunk) chunked_nxt = 1'b1;
          end
          phase_nxt = hrbp_pkg::PH_HDR_LF;
        end else if (phase_r == hrbp_pkg::PH_HDR_LWS &&
                     (b == hrbp_pkg::CH_SP || b == hrbp_pkg::CH_TAB)) begin
          phase_nxt = phase_r;
        end else if (hrbp_pkg::is_ctl(b)) begin
          err = 1'b1;
        end else begin
          phase_nxt = hrbp_pkg::PH_HDR_VALUE;
          cls       = hrbp_pkg::CL_HVALUE;
          val_nxt   = hrbp_pkg::match_step(val_r, val_same);
          // running length: spaces, then a sign, then digits
          if (num_ph_r == 2'd0 && b == hrbp_pkg::CH_SP) begin
            num_ph_nxt = num_ph_r;
          end else if (num_ph_r == 2'd0 && (b == "+" || b == "-")) begin
            num_neg_nxt = (b == "-");
            num_ph_nxt  = 2'd1;
          end else if (num_ph_r != 2'd3 && hrbp_pkg::is_digit(b)) begin
            num_nxt    = (dec_sum[LB+3:LB] != 4'd0) ? LEN_MAX : dec_sum[LB-1:0];
            num_ph_nxt = 2'd2;
          end else begin
            num_ph_nxt = 2'd3;
          end
        end
      end
      hrbp_pkg::PH_HDR_NAME: begin
        if (b == ":") begin
          phase_nxt = hrbp_pkg::PH_HDR_SPACE;
        end else if (!hrbp_pkg::is_token(b)) begin
          err = 1'b1;
        end else begin
          cls      = hrbp_pkg::CL_HNAME;
          name_nxt = hrbp_pkg::match_step(name_r, name_same);
        end
      end
      hrbp_pkg::PH_HDR_SPACE: begin
        if (b == hrbp_pkg::CH_SP) phase_nxt = hrbp_pkg::PH_HDR_VALUE;
        else err = 1'b1;
      end
      hrbp_pkg::PH_END_LF: begin
        if (b != hrbp_pkg::CH_LF) begin
          err = 1'b1;
        end else begin
          if (conn_r[0]) ka_nxt = conn_r[1];
          else if (major_r > 8'd1 || (major_r == 8'd1 && minor_r == 8'd1)) ka_nxt = 1'b1;
          if (chunked_r) phase_nxt = hrbp_pkg::PH_CK_SIZE;
          else if (body_r == '0) status = hrbp_pkg::ST_DONE;
          else phase_nxt = hrbp_pkg::PH_BODY;
        end
      end
      hrbp_pkg::PH_BODY: begin
        cls      = hrbp_pkg::CL_BODY;
        body_nxt = body_dec;
        if (body_dec == '0) status = hrbp_pkg::ST_DONE;
      end
      hrbp_pkg::PH_CK_SIZE: begin
        if (hrbp_pkg::is_alnum(b)) begin
          if (hex_open_r) begin
            if (hrbp_pkg::is_digit(b) || (bl >= "a" && bl <= "f")) begin
              hex_nxt = (hex_sum[LB+3:LB] != 4'd0) ? LEN_MAX : hex_sum[LB-1:0];
            end else begin
              hex_open_nxt = 1'b0;
            end
          end
        end else if (b == ";") begin
          phase_nxt = hrbp_pkg::PH_CK_EXT_NAME;
        end else if (b == hrbp_pkg::CH_CR) begin
          phase_nxt = hrbp_pkg::PH_CK_SIZE_LF;
        end else begin
          err = 1'b1;
        end
      end
      hrbp_pkg::PH_CK_EXT_NAME: begin
        if (hrbp_pkg::is_alnum(b) || b == hrbp_pkg::CH_SP) phase_nxt = phase_r;
        else if (b == "=") phase_nxt = hrbp_pkg::PH_CK_EXT_VALUE;
        else if (b == hrbp_pkg::CH_CR) phase_nxt = hrbp_pkg::PH_CK_SIZE_LF;
        else err = 1'b1;
      end
      hrbp_pkg::PH_CK_EXT_VALUE, hrbp_pkg::PH_CK_TRAILER_VALUE: begin
        if (hrbp_pkg::is_alnum(b) || b == hrbp_pkg::CH_SP) phase_nxt = phase_r;
        else if (b == hrbp_pkg::CH_CR) phase_nxt = hrbp_pkg::PH_CK_SIZE_LF;
        else err = 1'b1;
      end
      hrbp_pkg::PH_CK_SIZE_LF: begin
        if (b == hrbp_pkg::CH_LF) begin
          body_nxt     = hex_r;
          hex_nxt      = '0;
          hex_open_nxt = 1'b1;
          phase_nxt    = (hex_r == '0) ? hrbp_pkg::PH_CK_LAST : hrbp_pkg::PH_CK_DATA;
        end else begin
          err = 1'b1;
        end
      end
      hrbp_pkg::PH_CK_LAST: begin
        if (b == hrbp_pkg::CH_CR) phase_nxt = hrbp_pkg::PH_CK_FINAL_LF;
        else if (hrbp_pkg::is_alpha(b)) phase_nxt = hrbp_pkg::PH_CK_TRAILER_NAME;
        else err = 1'b1;
      end
      hrbp_pkg::PH_CK_FINAL_LF: begin
        if (b == hrbp_pkg::CH_LF) status = hrbp_pkg::ST_DONE;
        else err = 1'b1;
      end
      hrbp_pkg::PH_CK_TRAILER_NAME: begin
        if (hrbp_pkg::is_alnum(b)) phase_nxt = phase_r;
        else if (b == ":") phase_nxt = hrbp_pkg::PH_CK_TRAILER_VALUE;
        else err = 1'b1;
      end
      hrbp_pkg::PH_CK_DATA: begin
        cls      = hrbp_pkg::CL_BODY;
        body_nxt = body_dec;
        if (body_dec == '0) phase_nxt = hrbp_pkg::PH_CK_DATA_CR;
      end
      hrbp_pkg::PH_CK_DATA_CR: begin
        if (b == hrbp_pkg::CH_CR) phase_nxt = hrbp_pkg::PH_CK_DATA_LF;
        else err = 1'b1;
      end
      hrbp_pkg::PH_CK_DATA_LF: begin
        if (b == hrbp_pkg::CH_LF) phase_nxt = hrbp_pkg::PH_CK_SIZE;
        else err = 1'b1;
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (err) begin
      status = hrbp_pkg::ST_ERROR;
      cls    = hrbp_pkg::CL_FRAMING;
      hs     = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
    if (fire) begin
      out_data_r <= {chunked_nxt, ka_nxt, minor_nxt, major_nxt, b, status};
      out_user_r <= {hs, cls};
    end
  end

  // parse state; a completion or an error restarts the parser
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && status != hrbp_pkg::ST_INCOMPLETE)) begin
      phase_r    <= hrbp_pkg::PH_METHOD_START;
      meth_r     <= hrbp_pkg::MATCH_CLEAR;
      name_r     <= hrbp_pkg::MATCH_CLEAR;
      val_r      <= hrbp_pkg::MATCH_CLEAR;
      major_r    <= 8'd0;
      minor_r    <= 8'd0;
      any_hdr_r  <= 1'b0;
      num_r      <= '0;
      num_ph_r   <= 2'd0;
      num_neg_r  <= 1'b0;
      conn_r     <= 2'd0;
      body_r     <= '0;
      chunked_r  <= 1'b0;
      hex_r      <= '0;
      hex_open_r <= 1'b1;
      ka_r       <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      meth_r     <= meth_nxt;
      name_r     <= name_nxt;
      val_r      <= val_nxt;
      major_r    <= major_nxt;
      minor_r    <= minor_nxt;
      any_hdr_r  <= any_hdr_nxt;
      num_r      <= num_nxt;
      num_ph_r   <= num_ph_nxt;
      num_neg_r  <= num_neg_nxt;
      conn_r     <= conn_nxt;
      body_r     <= body_nxt;
      chunked_r  <= chunked_nxt;
      hex_r      <= hex_nxt;
      hex_open_r <= hex_open_nxt;
      ka_r       <= ka_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};
  assign out_tuser  = out_user_r;

endmodule

@@ src/hrbp_checker.sv @@
// port-level checks for the http request byte parser, bound to the top level
module hrbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_err_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == hrbp_pkg::ST_ERROR |->
      out_tuser == 4'd0)
    else $error("error result carries a class or header start");

  a_hstart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == hrbp_pkg::CL_HNAME)
    else $error("header start outside a header name");

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
